FILE: src/rate_paced_multi_queue_server_assert.svh
// Assertion macros shared by the queue server modules.
// Each check is clocked on the rising edge and disabled while reset is low.
`ifndef RATE_PACED_MULTI_QUEUE_SERVER_ASSERT_SVH
`define RATE_PACED_MULTI_QUEUE_SERVER_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication.
`define RPMQS_ASSERT_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("rpmqs assertion failed");
// Next-cycle implication.
`define RPMQS_ASSERT_NXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("rpmqs assertion failed");
`else
`define RPMQS_ASSERT_IMP(lbl, ck, rn, a, c)
`define RPMQS_ASSERT_NXT(lbl, ck, rn, a, c)
`endif
`endif

FILE: src/rpmqs_pkg.sv
package rpmqs_pkg;

    localparam int DEF_NUM_QUEUES  = 5;
    localparam int DEF_QUEUE_DEPTH = 64;

    localparam int RATE_REGS = 5;
    localparam int RATE_W    = 16;
    localparam int REQ_W     = 31;
    localparam int QID_W     = 3;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1);

    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RATE_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_C = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_D = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_E = CFG_IDX_W'(4);

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK    = 2'd0,
        KIND_SERVED = 2'd1,
        KIND_IDLE   = 2'd2
    } kind_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic enq;
        logic tick;
        logic pop;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic pop_any;
        logic pop_last;
    } dp_status_t;

endpackage

FILE: src/rate_paced_multi_queue_server.sv
// Enqueue: acknowledge in the cycle after start; a new item may follow every cycle
// while busy is low. Tick: with no queue due and nonempty, one idle result in the
// cycle after start; otherwise busy while the due, nonempty queues (1..NUM_QUEUES)
// are popped, one result a cycle, paced by the single read port of the shared store.
// Results appear on strobe for one cycle each. Reset (rst_n low, async) clears
// pointers, fill and pace counters, sets all rates to 1; the store is not cleared.
module rate_paced_multi_queue_server #(
    parameter int NUM_QUEUES  = rpmqs_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = rpmqs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             op,
    input  logic [rpmqs_pkg::QID_W-1:0]      queue_id,
    input  logic [rpmqs_pkg::REQ_W-1:0]      request,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rpmqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpmqs_pkg::RATE_W-1:0]     cfg_data,
    output logic                             strobe,
    output logic [rpmqs_pkg::KIND_W-1:0]     kind,
    output logic [rpmqs_pkg::QID_W-1:0]      served_queue,
    output logic [rpmqs_pkg::REQ_W-1:0]      served_request,
    output logic                             accepted,
    output logic                             all_empty,
    output logic                             last
);
    import rpmqs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    rpmqs_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    rpmqs_datapath #(
        .NUM_QUEUES  (NUM_QUEUES),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .queue_id       (queue_id),
        .request        (request),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .strobe         (strobe),
        .kind           (kind),
        .served_queue   (served_queue),
        .served_request (served_request),
        .accepted       (accepted),
        .all_empty      (all_empty),
        .last           (last)
    );

endmodule

FILE: src/rpmqs_datapath.sv
`include "rate_paced_multi_queue_server_assert.svh"

module rpmqs_datapath #(
    parameter int NUM_QUEUES  = rpmqs_pkg::DEF_NUM_QUEUES,
    parameter int QUEUE_DEPTH = rpmqs_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  rpmqs_pkg::dp_cmd_t               cmd,
    output rpmqs_pkg::dp_status_t            status,
    input  logic [rpmqs_pkg::QID_W-1:0]      queue_id,
    input  logic [rpmqs_pkg::REQ_W-1:0]      request,
    input  logic                             cfg_we,
    input  logic [rpmqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpmqs_pkg::RATE_W-1:0]     cfg_data,
    output logic                             strobe,
    output logic [rpmqs_pkg::KIND_W-1:0]     kind,
    output logic [rpmqs_pkg::QID_W-1:0]      served_queue,
    output logic [rpmqs_pkg::REQ_W-1:0]      served_request,
    output logic                             accepted,
    output logic                             all_empty,
    output logic                             last
);
    import rpmqs_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
    localparam logic [RATE_W-1:0] PACE_MAX = '1;
    localparam logic [RATE_W-1:0] PACE_ONE = RATE_W'(1);

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        next_ptr = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    logic [PTR_W-1:0]  head_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  head_next [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_next [NUM_QUEUES];
    logic [CNT_W-1:0]  fill_reg [NUM_QUEUES];
    logic [CNT_W-1:0]  fill_next [NUM_QUEUES];
    logic [RATE_W-1:0] pace_reg [NUM_QUEUES];
    logic [RATE_W-1:0] pace_next [NUM_QUEUES];
    logic [RATE_W-1:0] rate_reg [RATE_REGS];
    logic [RATE_W-1:0] rate_next [RATE_REGS];
    logic [NUM_QUEUES-1:0] pend_reg;
    logic [NUM_QUEUES-1:0] pend_next;

    logic              res_valid_reg;
    logic              res_valid_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [QID_W-1:0]  queue_reg;
    logic [QID_W-1:0]  queue_next;
    logic              accepted_reg;
    logic              accepted_next;
    logic              all_empty_reg;
    logic              all_empty_next;
    logic              last_reg;
    logic              last_next;

    logic [REQ_W-1:0]  mem [MEM_DEPTH];
    logic [REQ_W-1:0]  rd_data_reg;

    logic [NUM_QUEUES-1:0] due;
    logic [NUM_QUEUES-1:0] nonempty;
    logic [NUM_QUEUES-1:0] sel_oh;
    logic [NUM_QUEUES-1:0] enq_oh;
    logic [NUM_QUEUES-1:0] pend_rest;
    logic                  found;
    logic                  all_empty_now;
    logic                  pop_empty_after;
    logic [QID_W-1:0]      sel_num;
    logic [PTR_W-1:0]      head_sel;
    logic [PTR_W-1:0]      tail_sel;
    logic [CNT_W-1:0]      fill_enq;
    logic                  in_range;
    logic                  push_ok;
    logic [ADDR_W-1:0]     waddr;
    logic [ADDR_W-1:0]     raddr;

    // Per-queue decode: due flags, lowest pending queue, enqueue target
    always_comb begin
        found           = 1'b0;
        all_empty_now   = 1'b1;
        pop_empty_after = 1'b1;
        sel_oh          = '0;
        sel_num         = '0;
        head_sel        = '0;
        tail_sel        = '0;
        fill_enq        = '0;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            due[q]      = (pace_reg[q] == '0) || (pace_reg[q] >= rate_reg[q]);
            nonempty[q] = (fill_reg[q] != '0);
            enq_oh[q]   = (queue_id == QID_W'(q));
            if (nonempty[q]) begin
                all_empty_now = 1'b0;
            end
            if (pend_reg[q] && !found) begin
                found     = 1'b1;
                sel_oh[q] = 1'b1;
                sel_num   = QID_W'(q);
                head_sel  = head_reg[q];
            end
            if (enq_oh[q]) begin
                tail_sel = tail_reg[q];
                fill_enq = fill_reg[q];
            end
        end
        // Empty after this pop: only the popped queue may still hold its last word
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (fill_reg[q] != (sel_oh[q] ? CNT_ONE : '0)) begin
                pop_empty_after = 1'b0;
            end
        end
    end

    assign pend_rest = pend_reg & ~sel_oh;
    assign in_range  = (queue_id < QID_W'(NUM_QUEUES));
    assign push_ok   = in_range && (fill_enq < CNT_FULL);
    assign waddr     = ADDR_W'(ADDR_W'(queue_id) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(tail_sel);
    assign raddr     = ADDR_W'(ADDR_W'(sel_num) * ADDR_W'(QUEUE_DEPTH)) + ADDR_W'(head_sel);

    assign status.pop_any  = |(due & nonempty);
    assign status.pop_last = (pend_rest == '0);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        pace_next = pace_reg;
        rate_next = rate_reg;
        pend_next = pend_reg;

        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (cmd.enq && push_ok && enq_oh[q]) begin
                tail_next[q] = next_ptr(tail_reg[q]);
                fill_next[q] = fill_reg[q] + CNT_ONE;
            end
            if (cmd.pop && sel_oh[q]) begin
                head_next[q] = next_ptr(head_reg[q]);
                fill_next[q] = fill_reg[q] - CNT_ONE;
            end
            // Clear a due counter, then advance all; saturate at the top
            if (cmd.tick) begin
                if (due[q]) begin
                    pace_next[q] = PACE_ONE;
                end else if (pace_reg[q] != PACE_MAX) begin
                    pace_next[q] = pace_reg[q] + PACE_ONE;
                end
            end
        end

        if (cfg_we) begin
            case (cfg_index)
                REG_RATE_A: rate_next[0] = cfg_data;
                REG_RATE_B: rate_next[1] = cfg_data;
                REG_RATE_C: rate_next[2] = cfg_data;
                REG_RATE_D: rate_next[3] = cfg_data;
                REG_RATE_E: rate_next[4] = cfg_data;
                default: ;
            endcase
        end

        if (cmd.tick) begin
            pend_next = due & nonempty;
        end else if (cmd.pop) begin
            pend_next = pend_rest;
        end

        res_valid_next = cmd.enq || (cmd.tick && !status.pop_any) || cmd.pop;
        kind_next      = kind_reg;
        queue_next     = queue_reg;
        accepted_next  = accepted_reg;
        all_empty_next = all_empty_reg;
        last_next      = last_reg;
        if (cmd.enq) begin
            kind_next      = KIND_ACK;
            queue_next     = queue_id;
            accepted_next  = push_ok;
            all_empty_next = all_empty_now && !push_ok;
            last_next      = 1'b1;
        end else if (cmd.tick) begin
            kind_next      = KIND_IDLE;
            queue_next     = '0;
            accepted_next  = 1'b0;
            all_empty_next = all_empty_now;
            last_next      = 1'b1;
        end else if (cmd.pop) begin
            kind_next      = KIND_SERVED;
            queue_next     = sel_num;
            accepted_next  = 1'b0;
            all_empty_next = pop_empty_after;
            last_next      = status.pop_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                fill_reg[q] <= '0;
                pace_reg[q] <= '0;
            end
            for (int r = 0; r < RATE_REGS; r++) begin
                rate_reg[r] <= RATE_RESET;
            end
            pend_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            pace_reg      <= pace_next;
            rate_reg      <= rate_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        kind_reg      <= kind_next;
        queue_reg     <= queue_next;
        accepted_reg  <= accepted_next;
        all_empty_reg <= all_empty_next;
        last_reg      <= last_next;
    end

    // Shared queue store: push writes at the tail, pop reads the head
    always_ff @(posedge clk) begin
        if (cmd.enq && push_ok) begin
            mem[waddr] <= request;
        end
        if (cmd.pop) begin
            rd_data_reg <= mem[raddr];
        end
    end

    assign strobe         = res_valid_reg;
    assign kind           = kind_reg;
    assign served_queue   = queue_reg;
    assign served_request = (kind_reg == KIND_SERVED) ? rd_data_reg : '0;
    assign accepted       = accepted_reg;
    assign all_empty      = all_empty_reg;
    assign last           = last_reg;

    `RPMQS_ASSERT_IMP(a_pop_has_work, clk, rst_n, cmd.pop, pend_reg != '0)
    `RPMQS_ASSERT_NXT(a_pop_clears_one, clk, rst_n, cmd.pop, $countones(pend_reg) + 1 == $countones($past(pend_reg)))
    `RPMQS_ASSERT_IMP(a_last_drains, clk, rst_n, res_valid_reg && kind_reg == KIND_SERVED && last_reg, pend_reg == '0)

endmodule

FILE: src/rpmqs_ctrl.sv
`include "rate_paced_multi_queue_server_assert.svh"

module rpmqs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  op,
    input  rpmqs_pkg::dp_status_t status,
    output rpmqs_pkg::dp_cmd_t    cmd,
    output logic                  busy
);
    import rpmqs_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_TICK
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   take;

    assign take = start && !busy_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (take && op == OP_TICK && status.pop_any) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                // leave after the last due queue is popped
                if (status.pop_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        busy_next = (state_next == ST_TICK);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign cmd.enq  = take && op == OP_ENQ;
    assign cmd.tick = take && op == OP_TICK;
    assign cmd.pop  = (state_reg == ST_TICK);
    assign busy     = busy_reg;

    `RPMQS_ASSERT_NXT(a_tick_work_busy, clk, rst_n, cmd.tick && status.pop_any, busy)
    `RPMQS_ASSERT_NXT(a_last_pop_frees, clk, rst_n, cmd.pop && status.pop_last, !busy)
    `RPMQS_ASSERT_NXT(a_enq_stays_free, clk, rst_n, cmd.enq, !busy)

endmodule

FILE: dv/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rpmqs_pkg::*;

    localparam int NQ          = DEF_NUM_QUEUES;
    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int MAX_REPORTS = 10;
    localparam int N_DIRECTED  = 17;
    localparam logic [RATE_W-1:0] PACE_MAX = '1;
    localparam logic [RATE_W-1:0] RATE_SLOWEST = '1;
    // index past the rate registers; a write there changes nothing
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(7);

    typedef struct packed {
        kind_t            kind;
        logic [QID_W-1:0] queue_no;
        logic [REQ_W-1:0] req;
        logic             accepted;
        logic             all_empty;
        logic             last;
    } server_word_t;

    typedef struct packed {
        logic             op;
        logic [QID_W-1:0] qid;
        logic [REQ_W-1:0] req;
        logic             typed;
        server_word_t     word;
    } stim_row_t;

    // Rows with typed set carry their one expected word; the rest go through the predictor.
    localparam stim_row_t DIRECTED_TABLE [N_DIRECTED] = '{
        '{OP_TICK, 3'd0, 31'd0,          1'b1, '{KIND_IDLE, 3'd0, 31'd0, 1'b0, 1'b1, 1'b1}},
        '{OP_ENQ,  3'd7, 31'h7fff_ffff,  1'b1, '{KIND_ACK,  3'd7, 31'd0, 1'b0, 1'b1, 1'b1}},
        '{OP_ENQ,  3'd5, 31'd0,          1'b1, '{KIND_ACK,  3'd5, 31'd0, 1'b0, 1'b1, 1'b1}},
        '{OP_ENQ,  3'd6, 31'h2aaa_aaaa,  1'b1, '{KIND_ACK,  3'd6, 31'd0, 1'b0, 1'b1, 1'b1}},
        '{OP_ENQ,  3'd0, 31'h7fff_ffff,  1'b1, '{KIND_ACK,  3'd0, 31'd0, 1'b1, 1'b0, 1'b1}},
        '{OP_ENQ,  3'd1, 31'd0,          1'b1, '{KIND_ACK,  3'd1, 31'd0, 1'b1, 1'b0, 1'b1}},
        '{OP_ENQ,  3'd2, 31'h5555_5555,  1'b0, '0},
        '{OP_ENQ,  3'd3, 31'h2aaa_aaaa,  1'b0, '0},
        '{OP_ENQ,  3'd4, 31'd1,          1'b0, '0},
        '{OP_ENQ,  3'd4, 31'h4000_0000,  1'b0, '0},
        '{OP_TICK, 3'd7, 31'h7fff_ffff,  1'b0, '0},
        '{OP_TICK, 3'd3, 31'h1234_5678,  1'b0, '0},
        '{OP_TICK, 3'd0, 31'd0,          1'b1, '{KIND_IDLE, 3'd0, 31'd0, 1'b0, 1'b1, 1'b1}},
        '{OP_ENQ,  3'd3, 31'h1234_5678,  1'b0, '0},
        '{OP_ENQ,  3'd3, 31'h7fff_fffe,  1'b0, '0},
        '{OP_TICK, 3'd5, 31'h0000_ffff,  1'b0, '0},
        '{OP_TICK, 3'd2, 31'h7fff_0000,  1'b0, '0}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic                 op;
    logic [QID_W-1:0]     queue_id;
    logic [REQ_W-1:0]     request;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0]    cfg_data;
    logic                 strobe;
    logic [KIND_W-1:0]    res_kind;
    logic [QID_W-1:0]     res_queue;
    logic [REQ_W-1:0]     res_request;
    logic                 res_accepted;
    logic                 res_all_empty;
    logic                 res_last;

    // predictor state
    logic [REQ_W-1:0]  slot_mem [NQ*DEPTH];
    int                head_slot [NQ];
    int                tail_slot [NQ];
    int                fill_level [NQ];
    logic [RATE_W-1:0] pace_count [NQ];
    logic [RATE_W-1:0] rate_by_queue [NQ];

    server_word_t predicted [$];
    server_word_t expected_words [$];

    int mismatch_count = 0;
    int items_total    = 0;
    int enq_total      = 0;
    int drop_total     = 0;
    int tick_total     = 0;
    int served_total   = 0;
    int settings_total = 0;

    rate_paced_multi_queue_server u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .op             (op),
        .queue_id       (queue_id),
        .request        (request),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .strobe         (strobe),
        .kind           (res_kind),
        .served_queue   (res_queue),
        .served_request (res_request),
        .accepted       (res_accepted),
        .all_empty      (res_all_empty),
        .last           (res_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("rate_paced_multi_queue_server: mismatch");
        $finish;
    end

    function automatic logic queues_drained();
        int q;
        for (q = 0; q < NQ; q++)
        begin
            if (fill_level[q] != 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Work out the words one accepted item causes.
    task automatic predict_item(input logic op_v, input logic [QID_W-1:0] qid_v,
                                input logic [REQ_W-1:0] req_v);
        server_word_t w;
        logic         stored;
        int           q;
        begin
            predicted.delete();
            w = '0;
            if (op_v == OP_ENQ)
            begin
                enq_total++;
                stored = 1'b0;
                if (qid_v < NQ)
                begin
                    if (fill_level[qid_v] < DEPTH)
                    begin
                        slot_mem[qid_v*DEPTH + tail_slot[qid_v]] = req_v;
                        tail_slot[qid_v] = (tail_slot[qid_v] + 1) % DEPTH;
                        fill_level[qid_v]++;
                        stored = 1'b1;
                    end
                end
                if (!stored)
                    drop_total++;
                w.kind      = KIND_ACK;
                w.queue_no  = qid_v;
                w.accepted  = stored;
                w.all_empty = queues_drained();
                w.last      = 1'b1;
                predicted.insert(predicted.size(), w);
            end
            else
            begin
                tick_total++;
                for (q = 0; q < NQ; q++)
                begin
                    if (pace_count[q] == '0 || pace_count[q] >= rate_by_queue[q])
                    begin
                        pace_count[q] = '0;
                        if (fill_level[q] != 0)
                        begin
                            w.req = slot_mem[q*DEPTH + head_slot[q]];
                            head_slot[q] = (head_slot[q] + 1) % DEPTH;
                            fill_level[q]--;
                            w.kind      = KIND_SERVED;
                            w.queue_no  = QID_W'(q);
                            w.accepted  = 1'b0;
                            w.all_empty = queues_drained();
                            w.last      = 1'b0;
                            predicted.insert(predicted.size(), w);
                            served_total++;
                        end
                    end
                end
                for (q = 0; q < NQ; q++)
                begin
                    if (pace_count[q] != PACE_MAX)
                        pace_count[q]++;
                end
                if (predicted.size() == 0)
                begin
                    w           = '0;
                    w.kind      = KIND_IDLE;
                    w.all_empty = queues_drained();
                    w.last      = 1'b1;
                    predicted.insert(predicted.size(), w);
                end
                else
                begin
                    // flag the final word of this tick
                    predicted[predicted.size() - 1].last = 1'b1;
                end
            end
        end
    endtask

    // Called and returns at a falling edge.
    task automatic run_item(input logic op_v, input logic [QID_W-1:0] qid_v,
                            input logic [REQ_W-1:0] req_v, input logic typed,
                            input server_word_t typed_word, input int idle_pct);
        int gap;
        int k;
        begin
            gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
            if (gap != 0)
            begin
                start = 1'b0;
                repeat (gap)
                begin
                    op       = 1'($urandom);
                    queue_id = QID_W'($urandom);
                    request  = REQ_W'($urandom);
                    @(negedge clk);
                end
            end
            op       = op_v;
            queue_id = qid_v;
            request  = req_v;
            start    = 1'b1;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            items_total++;
            predict_item(op_v, qid_v, req_v);
            if (typed)
                expected_words.insert(expected_words.size(), typed_word);
            else
            begin
                for (k = 0; k < predicted.size(); k++)
                    expected_words.insert(expected_words.size(), predicted[k]);
            end
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] data);
        begin
            cfg_index = idx;
            cfg_data  = data;
            cfg_valid = 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx < NQ)
                rate_by_queue[idx] = data;
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    task automatic set_rates(input logic [RATE_W-1:0] ra, input logic [RATE_W-1:0] rb,
                             input logic [RATE_W-1:0] rc, input logic [RATE_W-1:0] rd,
                             input logic [RATE_W-1:0] re);
        begin
            write_reg(REG_RATE_A, ra);
            write_reg(REG_RATE_B, rb);
            write_reg(REG_RATE_C, rc);
            write_reg(REG_RATE_D, rd);
            write_reg(REG_RATE_E, re);
            settings_total++;
        end
    endtask

    // Hold until every expected word has come back, then let the block settle.
    task automatic wait_drained();
        begin
            start = 1'b0;
            while (expected_words.size() != 0)
                @(negedge clk);
            repeat (4)
                @(negedge clk);
        end
    endtask

    task automatic run_phase(input int n_items, input int idle_pct, input int enq_pct,
                             input int hot_pct, input int hot_q);
        int                i;
        int                roll;
        logic              op_v;
        logic [QID_W-1:0]  qid_v;
        logic [REQ_W-1:0]  req_v;
        begin
            for (i = 0; i < n_items; i++)
            begin
                req_v = REQ_W'($urandom);
                if ($urandom_range(99) < enq_pct)
                begin
                    op_v = OP_ENQ;
                    roll = $urandom_range(99);
                    if (roll < 8)
                        qid_v = QID_W'($urandom_range(NQ, 7));
                    else if (roll < 8 + hot_pct)
                        qid_v = QID_W'(hot_q);
                    else
                        qid_v = QID_W'($urandom_range(0, NQ - 1));
                end
                else
                begin
                    op_v  = OP_TICK;
                    qid_v = QID_W'($urandom);
                end
                run_item(op_v, qid_v, req_v, 1'b0, '0, idle_pct);
            end
        end
    endtask

    always @(posedge clk)
    begin : result_check
        server_word_t got;
        server_word_t want;
        if (rst_n && strobe)
        begin
            got = '{kind_t'(res_kind), res_queue, res_request, res_accepted,
                    res_all_empty, res_last};
            if (expected_words.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: word with none expected: kind %0d queue %0d req %h",
                             $realtime, got.kind, got.queue_no, got.req);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got.kind !== want.kind || got.queue_no !== want.queue_no ||
                    got.req !== want.req || got.accepted !== want.accepted ||
                    got.all_empty !== want.all_empty || got.last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                    begin
                        $display("%0t: expected kind %0d queue %0d req %h acc %b empty %b last %b",
                                 $realtime, want.kind, want.queue_no, want.req, want.accepted,
                                 want.all_empty, want.last);
                        $display("%0t: got      kind %0d queue %0d req %h acc %b empty %b last %b",
                                 $realtime, got.kind, got.queue_no, got.req, got.accepted,
                                 got.all_empty, got.last);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        int i;
        int drain_cycles;
        start     = 1'b0;
        op        = OP_ENQ;
        queue_id  = '0;
        request   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_RATE_A;
        cfg_data  = RATE_RESET;
        rst_n     = 1'b0;
        for (i = 0; i < NQ; i++)
        begin
            head_slot[i]     = 0;
            tail_slot[i]     = 0;
            fill_level[i]    = 0;
            pace_count[i]    = '0;
            rate_by_queue[i] = RATE_RESET;
        end
        repeat (10)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            run_item(DIRECTED_TABLE[i].op, DIRECTED_TABLE[i].qid, DIRECTED_TABLE[i].req,
                     DIRECTED_TABLE[i].typed, DIRECTED_TABLE[i].word, 0);
        wait_drained();

        set_rates(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_phase(100, 0, 55, 0, 0);
        wait_drained();

        // queue zero stalls at the slowest rate, so heavy enqueues overflow it
        set_rates(RATE_SLOWEST, 16'd2, 16'd3, 16'd5, 16'd1);
        run_phase(130, 85, 85, 75, 0);
        wait_drained();

        set_rates(RATE_W'($urandom_range(1, 9)), RATE_SLOWEST, 16'd1,
                  RATE_W'($urandom_range(2, 6)), 16'd3);
        write_reg(REG_UNMAPPED, RATE_W'($urandom));
        run_phase(130, 28, 50, 30, 2);
        wait_drained();

        set_rates(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        run_phase(120, 0, 20, 0, 0);
        start = 1'b0;

        drain_cycles = 0;
        while (expected_words.size() != 0 && drain_cycles < 2000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (8)
            @(negedge clk);
        if (expected_words.size() != 0)
        begin
            $display("%0d expected words never arrived", expected_words.size());
            mismatch_count += expected_words.size();
        end

        $display("ran %0d items over %0d rate settings: %0d enqueues (%0d dropped), %0d ticks",
                 items_total, settings_total, enq_total, drop_total, tick_total);
        $display("%0d requests served, %0d word errors", served_total, mismatch_count);
        if (mismatch_count == 0)
            $display("rate_paced_multi_queue_server: match");
        else
            $display("rate_paced_multi_queue_server: mismatch");
        $finish;
    end

endmodule

FILE: rate_paced_multi_queue_server.f
+incdir+src
src/rpmqs_pkg.sv
src/rpmqs_datapath.sv
src/rpmqs_ctrl.sv
src/rate_paced_multi_queue_server.sv
dv/tb_top.sv
